### hdl/sgra_pkg.sv
`default_nettype none
package sgra_pkg;

  // number of audio channels carried in one request
  localparam int CHANNELS = 2;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBFRAME_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBFRAMES_PER_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_SUBFRAME_SIZE = 2'd2;

  // register reset values
  localparam logic [10:0] SUBFRAME_SIZE_RST       = 11'd24;
  localparam logic [6:0]  SUBFRAMES_PER_FRAME_RST = 7'd20;
  localparam logic [16:0] RECIP_SUBFRAME_SIZE_RST = 17'd2731;
  localparam logic [15:0] UNITY_GAIN              = 16'd16384;

  // attack curve is squared this many times, giving the eighth power
  localparam int SQUARE_STEPS = 3;

  typedef struct packed {
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic [15:0]        target_gain;
  } in_t;

  typedef struct packed {
    logic signed [15:0] scaled_ch0;
    logic signed [15:0] scaled_ch1;
    logic [15:0]        gain_applied;
  } out_t;

endpackage
`default_nettype wire

### hdl/subframe_gain_ramp_applier_core.sv
`default_nettype none
// Per-sample gain ramp applier. Each request carries one sample per channel and the
// target gain (Q2.14) for the current subframe; the block derives one gain, a linear
// ramp from the previous subframe's gain or, in the first subframe of a frame with a
// falling gain, a (1-j/S)^8 attack curve, or with a subframe size of one the target
// itself, and returns every channel scaled by it, rounded to nearest with ties away
// from zero and saturated to 16 bits. All arithmetic runs through one shared 18x18
// multiplier with a registered product, under a small sequencer; in_ready is low while
// a request is in work. A request takes one multiply per channel with a subframe size
// of one; the linear ramp adds one for j*r and one for the gain step, and the attack
// curve adds three more for the squarings. The finished result sits in an output
// register, so the next request is taken while it waits; configuration writes are
// always accepted and should be issued only while the block is idle.
module subframe_gain_ramp_applier_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire sgra_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output sgra_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sgra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sgra_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MJR, S_PJR, S_MSQ, S_PSQ, S_MDF, S_PDF, S_MCH, S_PCH
  } state_t;

  state_t state_r;

  // configuration registers
  logic [10:0] subframe_size_r;
  logic [6:0]  subframes_per_frame_r;
  logic [16:0] recip_r;

  // block state
  logic [15:0] last_gain_r;
  logic [9:0]  pos_r;
  logic [5:0]  sf_idx_r;

  // request work registers
  sgra_pkg::in_t     req_r;
  logic              attack_r;
  logic              up_r;
  logic [1:0]        sq_cnt_r;
  logic [sgra_pkg::CH_W-1:0] ch_r;
  logic [15:0]       gain_r;
  logic signed [15:0] res_r [sgra_pkg::CHANNELS];
  logic              out_valid_r;
  sgra_pkg::out_t    out_data_r;

  // shared multiplier
  logic signed [17:0] op_a_r;
  logic signed [17:0] op_b_r;
  logic signed [35:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a_r * op_b_r;
  end

  // effective sizes with saturation
  logic [10:0] eff_size;
  logic [6:0]  eff_frames;
  always_comb begin
    if (subframe_size_r == 11'd0) eff_size = 11'd1;
    else if (subframe_size_r > 11'd1024) eff_size = 11'd1024;
    else eff_size = subframe_size_r;
    if (subframes_per_frame_r == 7'd0) eff_frames = 7'd1;
    else if (subframes_per_frame_r > 7'd64) eff_frames = 7'd64;
    else eff_frames = subframes_per_frame_r;
  end

  // request decode
  logic        in_acc;
  logic        acc_attack;
  logic        acc_up;
  logic [15:0] abs_diff;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign acc_attack = (sf_idx_r == 6'd0) && (last_gain_r > in_data.target_gain);
  assign acc_up     = (in_data.target_gain >= last_gain_r);
  assign abs_diff   = up_r ? (req_r.target_gain - last_gain_r)
                           : (last_gain_r - req_r.target_gain);

  // channel samples as an indexed view
  logic signed [15:0] samp [sgra_pkg::CHANNELS];
  logic signed [15:0] acc_samp0;
  assign samp[0] = req_r.sample_ch0;
  assign samp[1] = req_r.sample_ch1;
  assign acc_samp0 = in_data.sample_ch0;

  // q16 rounding of the product
  logic [34:0] rnd_sum;
  logic [16:0] rnd_q16;
  assign rnd_sum = {1'b0, prod_r[33:0]} + 35'd32768;
  assign rnd_q16 = rnd_sum[32:16];

  // attack start value and clamped linear fraction from j*r
  logic [16:0] f_start;
  logic [16:0] frac;
  always_comb begin
    if (prod_r[33:16] != 18'd0) f_start = 17'd0;
    else f_start = 17'h10000 - {1'b0, prod_r[15:0]};
    if (prod_r[33:0] > 34'h10000) frac = 17'h10000;
    else frac = prod_r[16:0];
  end

  // gain from the rounded step, clamped to 16 bits
  logic [18:0] g_wide;
  logic [15:0] g_new;
  always_comb begin
    if (attack_r) g_wide = {3'b0, req_r.target_gain} + {2'b0, rnd_q16};
    else if (up_r) g_wide = {3'b0, last_gain_r} + {2'b0, rnd_q16};
    else g_wide = {3'b0, last_gain_r} - {2'b0, rnd_q16};
    if (g_wide[18]) g_new = 16'd0;
    else if (g_wide[17:16] != 2'b00) g_new = 16'hFFFF;
    else g_new = g_wide[15:0];
  end

  // channel product: round q14 to nearest, ties away from zero, then saturate
  logic signed [33:0] p_ch;
  logic [33:0]        p_mag;
  logic [33:0]        q_sum;
  logic [19:0]        q_mag;
  logic signed [15:0] q_sat;
  always_comb begin
    p_ch  = prod_r[33:0];
    p_mag = p_ch[33] ? (34'd0 - p_ch) : p_ch;
    q_sum = p_mag + 34'd8192;
    q_mag = q_sum[33:14];
    if (!p_ch[33]) begin
      if (q_mag > 20'd32767) q_sat = 16'sh7FFF;
      else q_sat = q_mag[15:0];
    end else begin
      if (q_mag > 20'd32768) q_sat = 16'sh8000;
      else q_sat = 16'(20'd0 - q_mag);
    end
  end

  // results with the current channel merged in
  logic signed [15:0] cur_res [sgra_pkg::CHANNELS];
  always_comb begin
    for (int i = 0; i < sgra_pkg::CHANNELS; i++) begin
      cur_res[i] = (ch_r == sgra_pkg::CH_W'(i)) ? q_sat : res_r[i];
    end
  end

  logic last_ch;
  logic out_free;
  logic out_load;
  logic sf_end;
  assign last_ch  = (ch_r == sgra_pkg::CH_W'(sgra_pkg::CHANNELS - 1));
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_PCH) && last_ch && out_free;
  assign sf_end   = ({1'b0, pos_r} + 11'd1 >= eff_size);

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r               <= S_IDLE;
      subframe_size_r       <= sgra_pkg::SUBFRAME_SIZE_RST;
      subframes_per_frame_r <= sgra_pkg::SUBFRAMES_PER_FRAME_RST;
      recip_r               <= sgra_pkg::RECIP_SUBFRAME_SIZE_RST;
      last_gain_r           <= sgra_pkg::UNITY_GAIN;
      pos_r                 <= 10'd0;
      sf_idx_r              <= 6'd0;
      out_valid_r           <= 1'b0;
    end else begin
      // configuration write request
      if (cfg_valid) begin
        case (cfg_index)
          sgra_pkg::CFG_SUBFRAME_SIZE:       subframe_size_r <= cfg_data[10:0];
          sgra_pkg::CFG_SUBFRAMES_PER_FRAME: subframes_per_frame_r <= cfg_data[6:0];
          sgra_pkg::CFG_RECIP_SUBFRAME_SIZE: recip_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r    <= in_data;
            attack_r <= acc_attack;
            up_r     <= acc_up;
            if (eff_size == 11'd1) begin
              // subframe of one: target applies directly
              gain_r  <= in_data.target_gain;
              ch_r    <= '0;
              op_a_r  <= {{2{acc_samp0[15]}}, acc_samp0};
              op_b_r  <= {2'b00, in_data.target_gain};
              state_r <= S_MCH;
            end else begin
              op_a_r  <= {8'd0, pos_r};
              op_b_r  <= {1'b0, recip_r};
              state_r <= S_MJR;
            end
          end
        end
        S_MJR: state_r <= S_PJR;
        S_PJR: begin
          if (attack_r) begin
            op_a_r   <= {1'b0, f_start};
            op_b_r   <= {1'b0, f_start};
            sq_cnt_r <= 2'd0;
            state_r  <= S_MSQ;
          end else begin
            op_a_r  <= {1'b0, frac};
            op_b_r  <= {2'b00, abs_diff};
            state_r <= S_MDF;
          end
        end
        S_MSQ: state_r <= S_PSQ;
        S_PSQ: begin
          op_a_r <= {1'b0, rnd_q16};
          if (sq_cnt_r == 2'(sgra_pkg::SQUARE_STEPS - 1)) begin
            op_b_r  <= {2'b00, abs_diff};
            state_r <= S_MDF;
          end else begin
            op_b_r   <= {1'b0, rnd_q16};
            sq_cnt_r <= sq_cnt_r + 2'd1;
            state_r  <= S_MSQ;
          end
        end
        S_MDF: state_r <= S_PDF;
        S_PDF: begin
          gain_r  <= g_new;
          ch_r    <= '0;
          op_a_r  <= {{2{samp[0][15]}}, samp[0]};
          op_b_r  <= {2'b00, g_new};
          state_r <= S_MCH;
        end
        S_MCH: state_r <= S_PCH;
        S_PCH: begin
          if (!last_ch) begin
            res_r[ch_r] <= q_sat;
            ch_r        <= ch_r + 1'b1;
            op_a_r      <= {{2{samp[ch_r + 1'b1][15]}}, samp[ch_r + 1'b1]};
            state_r     <= S_MCH;
          end else if (out_free) begin
            // load the result register and advance subframe position
            out_data_r.scaled_ch0   <= cur_res[0];
            out_data_r.scaled_ch1   <= cur_res[1];
            out_data_r.gain_applied <= gain_r;
            out_valid_r             <= 1'b1;
            if (sf_end) begin
              pos_r       <= 10'd0;
              last_gain_r <= req_r.target_gain;
              if ({1'b0, sf_idx_r} + 7'd1 >= eff_frames) sf_idx_r <= 6'd0;
              else sf_idx_r <= sf_idx_r + 6'd1;
            end else begin
              pos_r <= pos_r + 10'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a taken request keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("block ready right after accepting a request");

  // a result only appears from the last channel step
  a_out_from_pch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_PCH))
    else $error("result raised outside the last channel step");

  // the gain step is always followed by a channel multiply
  a_pdf_to_mch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PDF) |=> (state_r == S_MCH))
    else $error("gain step not followed by channel multiply");

  // a finished request never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PCH && last_ch && out_valid_r && !out_ready) |=> (state_r == S_PCH))
    else $error("result register overwritten while waiting");

endmodule
`default_nettype wire

### tb/sv/tb_subframe_gain_ramp_applier_core.sv
`timescale 1ns / 100ps

module tb_subframe_gain_ramp_applier_core;

  localparam int N_DIR = 32;
  localparam int N_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 118;
  localparam int QUIET_CYCLES = 20;
  localparam int END_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_MAX = 10;
  // index with no register behind it
  localparam logic [sgra_pkg::CFG_IDX_W-1:0] CFG_UNUSED_SLOT = 2'd3;

  typedef enum int {DRAIN_FREE, DRAIN_SPOTTY, DRAIN_CHOKED} drain_mode_t;

  // one row of the directed part: a register write or a request
  typedef struct packed {
    logic                            is_cfg;
    logic [sgra_pkg::CFG_IDX_W-1:0]  idx;
    logic [sgra_pkg::CFG_DATA_W-1:0] val;
    sgra_pkg::in_t                   req;
    logic                            fixed;
    sgra_pkg::out_t                  want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sgra_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sgra_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sgra_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sgra_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // gain model state and register copies
  logic [10:0] reg_size = sgra_pkg::SUBFRAME_SIZE_RST;
  logic [6:0]  reg_frames = sgra_pkg::SUBFRAMES_PER_FRAME_RST;
  logic [16:0] reg_recip = sgra_pkg::RECIP_SUBFRAME_SIZE_RST;
  logic [15:0] held_gain = sgra_pkg::UNITY_GAIN;
  logic [9:0]  pos_q = '0;
  logic [5:0]  frame_pos_q = '0;

  sgra_pkg::out_t pending_scaled[$];
  int mismatches = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int mode_left = 0;

  dir_row_t dir_rows [N_DIR];

  subframe_gain_ramp_applier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // directed row builders
  function automatic dir_row_t req_row(int s0, int s1, int tgt);
    dir_row_t r;
    r = '0;
    r.req.sample_ch0 = 16'(s0);
    r.req.sample_ch1 = 16'(s1);
    r.req.target_gain = 16'(tgt);
    return r;
  endfunction

  function automatic dir_row_t fixed_row(int s0, int s1, int tgt, int o0, int o1, int og);
    dir_row_t r;
    r = req_row(s0, s1, tgt);
    r.fixed = 1'b1;
    r.want.scaled_ch0 = 16'(o0);
    r.want.scaled_ch1 = 16'(o1);
    r.want.gain_applied = 16'(og);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [sgra_pkg::CFG_IDX_W-1:0] idx, int val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = sgra_pkg::CFG_DATA_W'(val);
    return r;
  endfunction

  function automatic int unsigned eff_size();
    if (reg_size == 0) return 1;
    if (reg_size > 1024) return 1024;
    return reg_size;
  endfunction

  // per-sample gain: linear ramp, or eighth-power attack in the first subframe
  function automatic logic [15:0] ramp_gain(logic [15:0] target);
    longint unsigned jr, f;
    longint g;
    jr = 64'(pos_q) * 64'(reg_recip);
    if (eff_size() == 1) begin
      g = target;
    end else if (frame_pos_q == 0 && held_gain > target) begin
      f = (jr >= 65536) ? 0 : 65536 - jr;
      repeat (sgra_pkg::SQUARE_STEPS) f = (f * f + 32768) >> 16;
      g = longint'(target) + longint'((f * 64'(held_gain - target) + 32768) >> 16);
    end else begin
      f = (jr > 65536) ? 65536 : jr;
      if (target >= held_gain)
        g = longint'(held_gain) + longint'((f * 64'(target - held_gain) + 32768) >> 16);
      else
        g = longint'(held_gain) - longint'((f * 64'(held_gain - target) + 32768) >> 16);
    end
    if (g < 0) g = 0;
    if (g > 65535) g = 65535;
    return g[15:0];
  endfunction

  // sample times gain in Q2.14, ties away from zero, saturated
  function automatic logic signed [15:0] scale_sample(logic signed [15:0] x, logic [15:0] g);
    longint p, q;
    p = longint'(x) * longint'({1'b0, g});
    if (p >= 0) q = (p + 8192) / 16384;
    else q = -((-p + 8192) / 16384);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // expected result of one request, then advance subframe and frame counters
  function automatic sgra_pkg::out_t gain_ramp_step(sgra_pkg::in_t x);
    sgra_pkg::out_t r;
    logic [15:0] g;
    int unsigned nf;
    g = ramp_gain(x.target_gain);
    r.scaled_ch0 = scale_sample(x.sample_ch0, g);
    r.scaled_ch1 = scale_sample(x.sample_ch1, g);
    r.gain_applied = g;
    nf = (reg_frames == 0) ? 1 : (reg_frames > 64) ? 64 : reg_frames;
    if (int'(pos_q) + 1 >= int'(eff_size())) begin
      pos_q = '0;
      held_gain = x.target_gain;
      frame_pos_q = (int'(frame_pos_q) + 1 >= int'(nf)) ? 6'd0 : frame_pos_q + 6'd1;
    end else begin
      pos_q = pos_q + 10'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // sender bursts, random gaps and the occasional full drain
  task automatic pace_sender();
    if ($urandom_range(0, 149) == 0) begin
      in_valid <= 1'b0;
      while (pending_scaled.size() != 0) @(posedge clk);
      @(posedge clk);
    end else if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // present one request, hold it until taken, queue what it should produce
  task automatic drive_request(sgra_pkg::in_t x, logic use_fixed, sgra_pkg::out_t want);
    sgra_pkg::out_t predicted;
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    predicted = gain_ramp_step(x);
    pending_scaled.push_back(use_fixed ? want : predicted);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(logic [sgra_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgra_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sgra_pkg::CFG_SUBFRAME_SIZE:       reg_size = val[10:0];
      sgra_pkg::CFG_SUBFRAMES_PER_FRAME: reg_frames = val[6:0];
      sgra_pkg::CFG_RECIP_SUBFRAME_SIZE: reg_recip = val;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch %s: expected %0d got %0d", name, want, got);
    end
  endtask

  // receiver stall pattern, switching between modes
  always @(posedge clk) begin
    if (mode_left == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (drain_mode)
      DRAIN_FREE:   out_ready <= 1'b1;
      DRAIN_SPOTTY: out_ready <= ($urandom_range(0, 3) != 0);
      default:      out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    sgra_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_scaled.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: ch0 %0d ch1 %0d gain %0d",
                   out_data.scaled_ch0, out_data.scaled_ch1, out_data.gain_applied);
      end else begin
        want = pending_scaled.pop_front();
        check_field("scaled_ch0", longint'(want.scaled_ch0), longint'(out_data.scaled_ch0));
        check_field("scaled_ch1", longint'(want.scaled_ch1), longint'(out_data.scaled_ch1));
        check_field("gain_applied", longint'(want.gain_applied),
                    longint'(out_data.gain_applied));
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_subframe_gain_ramp_applier_core NOT OK");
      $finish;
    end
  end

  initial begin
    int ph, n;
    int unsigned sz, fr, rc;
    logic [15:0] cur_target;
    sgra_pkg::in_t req;

    dir_rows = '{
      // unity gain right after reset, whichever way the target points
      fixed_row(32767, -32768, 0, 32767, -32768, 16384),
      // attack toward zero in the first subframe
      req_row(12345, -12345, 0),
      req_row(-1, 1, 0),
      req_row(32767, -32768, 0),
      req_row(0, 0, 0),
      // subframe size one: target applies directly
      cfg_row(sgra_pkg::CFG_SUBFRAME_SIZE, 1),
      fixed_row(20000, -20000, 32768, 32767, -32768, 32768),
      fixed_row(3, -3, 8192, 2, -2, 8192),
      fixed_row(-1, 1, 8192, -1, 1, 8192),
      fixed_row(32767, -32768, 65535, 32767, -32768, 65535),
      fixed_row(1000, -1000, 0, 0, 0, 0),
      fixed_row(12345, -7, 16384, 12345, -7, 16384),
      // short subframes, falling then rising gain
      cfg_row(sgra_pkg::CFG_SUBFRAME_SIZE, 4),
      cfg_row(sgra_pkg::CFG_SUBFRAMES_PER_FRAME, 2),
      cfg_row(sgra_pkg::CFG_RECIP_SUBFRAME_SIZE, 16384),
      req_row(1000, -1000, 0),
      req_row(1000, -1000, 0),
      req_row(1000, -1000, 0),
      req_row(1000, -1000, 0),
      req_row(-20000, 20000, 65535),
      req_row(-20000, 20000, 65535),
      req_row(-20000, 20000, 65535),
      req_row(-20000, 20000, 65535),
      // write to the empty slot, then an oversized reciprocal
      cfg_row(CFG_UNUSED_SLOT, 'h1FFFF),
      cfg_row(sgra_pkg::CFG_RECIP_SUBFRAME_SIZE, 'h1FFFF),
      req_row(5, -5, 100),
      req_row(5, -5, 100),
      req_row(5, -5, 100),
      req_row(5, -5, 100),
      // zero reciprocal holds the previous gain
      cfg_row(sgra_pkg::CFG_RECIP_SUBFRAME_SIZE, 0),
      req_row(30000, -30000, 40000),
      req_row(30000, -30000, 40000)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        pace_sender();
        drive_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // random part, one register setting per phase
    cur_target = sgra_pkg::UNITY_GAIN;
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin sz = 1; fr = 1; rc = 65536; end
        1: begin sz = 2; fr = 1; rc = 32768; end
        2: begin sz = 3; fr = 2; rc = 21845; end
        3: begin sz = 1024; fr = 64; rc = 64; end
        4: begin sz = 0; fr = 0; rc = 0; end
        5: begin sz = 'h1FFFF; fr = 'h1FFFF; rc = 64; end
        6: begin sz = 8; fr = 3; rc = 'h1FFFF; end
        7: begin sz = 16; fr = 2; rc = 0; end
        8: begin sz = 24; fr = 20; rc = 2731; end
        default: begin
          sz = $urandom_range(2, 24);
          fr = $urandom_range(1, 6);
          rc = (65536 + sz / 2) / sz;
          if ($urandom_range(0, 3) == 0) rc = rc + $urandom_range(0, 64) - 32;
        end
      endcase
      write_reg(sgra_pkg::CFG_SUBFRAME_SIZE, sgra_pkg::CFG_DATA_W'(sz));
      write_reg(sgra_pkg::CFG_SUBFRAMES_PER_FRAME, sgra_pkg::CFG_DATA_W'(fr));
      write_reg(sgra_pkg::CFG_RECIP_SUBFRAME_SIZE, sgra_pkg::CFG_DATA_W'(rc));

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // target mostly held per subframe, now and then moved mid-subframe
        if (pos_q == 0 || $urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 7))
            0: cur_target = 16'h0000;
            1: cur_target = 16'hFFFF;
            2: cur_target = held_gain;
            3: cur_target = held_gain + 16'($urandom_range(0, 64) - 32);
            default: cur_target = 16'($urandom);
          endcase
        end
        req.sample_ch0 = pick_sample();
        req.sample_ch1 = pick_sample();
        req.target_gain = cur_target;
        pace_sender();
        drive_request(req, 1'b0, '0);
      end
    end

    // wind down
    in_valid <= 1'b0;
    while (pending_scaled.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_subframe_gain_ramp_applier_core OK");
    else
      $display("tb_subframe_gain_ramp_applier_core NOT OK");
    $finish;
  end

endmodule
